// ===== rtl/core/asdst_pkg.sv =====
// Package for the array search / delete / sort table.
// Holds operation and status codes, field widths and the result word type.
// No dependencies.
package asdst_pkg;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int IDX_W = 7;
    localparam int ST_W  = 3;
    localparam int POS_W = 7;
    localparam int CNT_W = 8;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 3'd0,
        OP_APPEND  = 3'd1,
        OP_READ    = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_DEL_IDX = 3'd4,
        OP_DEL_VAL = 3'd5,
        OP_SORT    = 3'd6,
        OP_MAX     = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Packed so that status lands in the lowest bits of the output word.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] data;
        logic [POS_W-1:0] position;
        t_status          status;
    } t_result;

endpackage

// ===== rtl/core/asdst_ram.sv =====
// Single-port-write, single-port-read synchronous memory for the table store.
// Read data is registered. No dependencies.
module asdst_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/asdst_ctrl.sv =====
// Sequencer for the table: decodes one operation, streams reads through the
// store memory and writes back shifted or exchanged entries.
// Depends on asdst_pkg; drives the ports of asdst_ram.
module asdst_ctrl
    import asdst_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // item in
    input  logic             i_valid,
    output logic             o_ready,
    input  t_op              i_op,
    input  logic [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0] i_index,
    // result out
    output logic             o_res_valid,
    input  logic             i_res_free,
    output t_result          o_res,
    // store memory
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output logic [VAL_W-1:0] o_wdata,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  logic [VAL_W-1:0] i_rdata
);

    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READW,
        S_SCAN,
        S_SHIFT,
        S_SORT,
        S_SORTWB,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_ra, n_ra;
    logic             r_dv, n_dv;
    logic [AW-1:0]    r_da, n_da;
    logic [AW-1:0]    r_i, n_i;
    logic [VAL_W-1:0] r_cur, n_cur;
    logic [AW-1:0]    r_mpos, n_mpos;
    t_status          r_status, n_status;
    logic [POS_W-1:0] r_rpos, n_rpos;
    logic [VAL_W-1:0] r_rdata, n_rdata;

    logic             issue;
    logic             idx_bad;
    logic [VAL_W-1:0] max_v;
    logic [AW-1:0]    max_p;

    assign issue   = (r_ra < r_cnt);
    assign idx_bad = (XW'(i_index) >= XW'(r_cnt));

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_cnt    = r_cnt;
        n_ra     = r_ra;
        n_dv     = r_dv;
        n_da     = r_da;
        n_i      = r_i;
        n_cur    = r_cur;
        n_mpos   = r_mpos;
        n_status = r_status;
        n_rpos   = r_rpos;
        n_rdata  = r_rdata;
        o_we     = 1'b0;
        o_waddr  = '0;
        o_wdata  = r_cur;
        o_re     = 1'b0;
        o_raddr  = r_ra[AW-1:0];
        max_v    = r_cur;
        max_p    = r_mpos;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_op;
                    n_val    = i_value;
                    n_status = ST_OK;
                    n_rpos   = '0;
                    n_rdata  = '0;
                    n_dv     = 1'b0;
                    n_ra     = '0;
                    n_i      = '0;
                    n_state  = S_DONE;
                    if (i_op == OP_CLEAR) begin
                        n_cnt = '0;
                    end else if (i_op == OP_APPEND) begin
                        if (r_cnt == CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_cnt[AW-1:0];
                            o_wdata = i_value;
                            n_cnt   = r_cnt + CW'(1);
                        end
                    end else if (r_cnt == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        unique case (i_op)
                            OP_READ: begin
                                if (idx_bad) begin
                                    n_status = ST_RANGE;
                                end else begin
                                    o_re    = 1'b1;
                                    o_raddr = AW'(i_index);
                                    n_state = S_READW;
                                end
                            end
                            OP_DEL_IDX: begin
                                if (idx_bad) begin
                                    n_status = ST_RANGE;
                                end else begin
                                    n_ra    = CW'(i_index) + CW'(1);
                                    n_state = S_SHIFT;
                                end
                            end
                            OP_SORT: begin
                                if (r_cnt != CW'(1)) begin
                                    n_state = S_SORT;
                                end
                            end
                            OP_SEARCH, OP_DEL_VAL, OP_MAX: begin
                                n_state = S_SCAN;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_READW: begin
                n_rdata = i_rdata;
                n_state = S_DONE;
            end

            S_SCAN: begin
                o_re = issue;
                n_dv = issue;
                n_da = r_ra[AW-1:0];
                if (issue) begin
                    n_ra = r_ra + CW'(1);
                end
                if (r_dv) begin
                    if (r_op == OP_MAX) begin
                        if (r_da == '0 || $signed(i_rdata) > $signed(r_cur)) begin
                            max_v = i_rdata;
                            max_p = r_da;
                        end
                        n_cur  = max_v;
                        n_mpos = max_p;
                    end else if (i_rdata == r_val) begin
                        // first hit: search reports, delete goes on to the shift
                        n_dv = 1'b0;
                        if (r_op == OP_SEARCH) begin
                            n_rpos  = POS_W'(r_da);
                            n_state = S_DONE;
                        end else begin
                            n_ra    = CW'(r_da) + CW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                end else if (!issue) begin
                    n_state = S_DONE;
                    if (r_op == OP_MAX) begin
                        n_rpos  = POS_W'(r_mpos);
                        n_rdata = r_cur;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT: begin
                o_re = issue;
                n_dv = issue;
                n_da = r_ra[AW-1:0];
                if (issue) begin
                    n_ra = r_ra + CW'(1);
                end
                if (r_dv) begin
                    o_we    = 1'b1;
                    o_waddr = r_da - AW'(1);
                    o_wdata = i_rdata;
                end else if (!issue) begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_DONE;
                end
            end

            S_SORT: begin
                // r_cur holds entry i; swap out each smaller entry as it streams by
                o_re = issue;
                n_dv = issue;
                n_da = r_ra[AW-1:0];
                if (issue) begin
                    n_ra = r_ra + CW'(1);
                end
                if (r_dv) begin
                    if (r_da == r_i) begin
                        n_cur = i_rdata;
                    end else if ($signed(i_rdata) < $signed(r_cur)) begin
                        o_we    = 1'b1;
                        o_waddr = r_da;
                        o_wdata = r_cur;
                        n_cur   = i_rdata;
                    end
                end else if (!issue) begin
                    n_state = S_SORTWB;
                end
            end

            S_SORTWB: begin
                o_we    = 1'b1;
                o_waddr = r_i;
                o_wdata = r_cur;
                n_i     = r_i + AW'(1);
                n_dv    = 1'b0;
                if (CW'(r_i) + CW'(2) >= r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_ra    = CW'(r_i) + CW'(1);
                    n_state = S_SORT;
                end
            end

            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= n_dv;
        end
        r_op     <= n_op;
        r_val    <= n_val;
        r_ra     <= n_ra;
        r_da     <= n_da;
        r_i      <= n_i;
        r_cur    <= n_cur;
        r_mpos   <= n_mpos;
        r_status <= n_status;
        r_rpos   <= n_rpos;
        r_rdata  <= n_rdata;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.count    = CNT_W'(r_cnt);
        o_res.data     = r_rdata;
        o_res.position = r_rpos;
        o_res.status   = r_status;
    end

endmodule

// ===== rtl/core/array_search_delete_sort_table.sv =====
// Table of up to DEPTH signed Q16.16 words with append, read, search, delete
// (by index or first equal value, later entries shift down), ascending
// exchange sort and first-maximum. One operation per input word, one result
// word each. Entries live in a single synchronous RAM (one write and one
// registered read port); a sequencer streams one entry per cycle through it.
// Work per word, n = used entries: clear, append and error cases need no
// read; read waits for the registered read; search, delete-by-value and max
// scan up to n entries; delete then shifts the entries after the position
// down; sort walks the single read port once per outer pass.
// The input is taken only when the sequencer is idle; a finished result sits
// in the output register while the next word is accepted. No clearing pass
// after reset: the store is valid only below the count.
// Depends on asdst_pkg, asdst_ram and asdst_ctrl.
module array_search_delete_sort_table
    import asdst_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // op[2:0], value[34:3], index[41:35], zero fill [47:42]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[2:0], position[9:3], data[41:10], count[49:42], zero fill [55:50]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             ctrl_ready;
    logic             res_valid;
    logic             res_free;
    t_result          res;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [VAL_W-1:0] rdata;

    logic             r_m_valid;
    t_result          r_m_res;

    // output slot is free when empty or drained this cycle
    assign res_free = !r_m_valid || i_m_axis_tready;

    asdst_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (ctrl_ready),
        .i_op        (t_op'(i_s_axis_tdata[OP_W-1:0])),
        .i_value     (i_s_axis_tdata[OP_W +: VAL_W]),
        .i_index     (i_s_axis_tdata[OP_W+VAL_W +: IDX_W]),
        .o_res_valid (res_valid),
        .i_res_free  (res_free),
        .o_res       (res),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    asdst_ram #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res_valid && res_free) begin
            r_m_res <= res;
        end
    end

    assign o_s_axis_tready = ctrl_ready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_m_res);

endmodule
